/* rtl/usd_pkg.sv */
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants of the utf stream decoder
// item layouts, encoding codes, status codes, unit lengths and utf-8 lead thresholds
// ----------------------------------------------------------------------------
`default_nettype none

package usd_pkg;

    // encoding register codes
    localparam logic [2:0] ENC_UTF8     = 3'd0;
    localparam logic [2:0] ENC_UTF16_BE = 3'd1;
    localparam logic [2:0] ENC_UTF16_LE = 3'd2;
    localparam logic [2:0] ENC_UTF32_BE = 3'd3;
    localparam logic [2:0] ENC_UTF32_LE = 3'd4;

    // input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_CHAR      = 2'd0;
    localparam logic [1:0] ST_END_CLEAN = 2'd1;
    localparam logic [1:0] ST_END_TRUNC = 2'd2;

    // utf-8 lead byte thresholds
    localparam logic [7:0] LEAD6 = 8'hfc;
    localparam logic [7:0] LEAD5 = 8'hf8;
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] CONT_MASK = 8'h3f;

    // unit lengths of the fixed width encodings
    localparam logic [2:0] LEN_UTF16 = 3'd2;
    localparam logic [2:0] LEN_UTF32 = 3'd4;

    localparam int CP_W = 31;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/utf_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf_stream_decoder: byte stream to code point decoder
// utf-8 (legacy 31-bit form), utf-16 (units, surrogates not paired) and utf-32 in either byte order
// ----------------------------------------------------------------------------
// a result enters the result register, or the skid register while that one is held
// throughput: one byte item per cycle while byte_ready is high; decode is one shift
// and mask pass between the accepted item and the state and result registers
// a two-entry output (result register plus skid register) lets an item be taken
// while a result waits; byte_ready drops only while the skid register is full
// reset: encoding returns to utf-8, no unit in progress, both output entries empty
`default_nettype none

module utf_stream_decoder
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  byte_valid,
    output logic                 byte_ready,
    input  wire usd_pkg::in_item_t byte_item,

    output logic                 cp_valid,
    input  wire                  cp_ready,
    output usd_pkg::out_item_t   cp_item,

    input  wire                  cfg_we,
    input  wire  [2:0]           cfg_data
);

    localparam int CW = usd_pkg::CP_W;

    // configuration and unit state
    logic [2:0]    enc_reg,    enc_next;
    logic [2:0]    needed_reg, needed_next;
    logic [2:0]    seen_reg,   seen_next;
    logic [CW-1:0] acc_reg,    acc_next;

    // output entries
    logic               out_valid_reg,  out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    usd_pkg::out_item_t out_reg,        out_next;
    usd_pkg::out_item_t skid_reg,       skid_next;

    // decode step
    logic               accept;
    logic               res_valid;
    usd_pkg::out_item_t res;
    logic [7:0]         b;
    logic [2:0]         unit_len;
    logic [2:0]         seen_base;
    logic [CW-1:0]      acc_base;
    logic               out_take;

    assign byte_ready = !skid_valid_reg;
    assign accept     = byte_valid && byte_ready;
    assign b          = byte_item.data_byte;
    assign out_take   = out_valid_reg && cp_ready;
    assign cp_valid   = out_valid_reg;
    assign cp_item    = out_reg;

    always_comb
    begin
        enc_next    = enc_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        res_valid   = 1'b0;
        res         = '{code_point: '0, status: usd_pkg::ST_CHAR};
        unit_len    = usd_pkg::LEN_UTF16;
        seen_base   = seen_reg;
        acc_base    = acc_reg;

        if (accept)
        begin
            if (byte_item.kind == usd_pkg::KIND_END)
            begin
                // close the stream; only an open utf-8 sequence counts as cut short
                res_valid     = 1'b1;
                res.status    = (enc_reg == usd_pkg::ENC_UTF8 && needed_reg != 3'd0) ?
                                usd_pkg::ST_END_TRUNC : usd_pkg::ST_END_CLEAN;
                needed_next   = '0;
                seen_next     = '0;
                acc_next      = '0;
            end
            else
            begin
                case (enc_reg)
                    usd_pkg::ENC_UTF8:
                    begin
                        if (needed_reg == 3'd0)
                        begin
                            // lead byte sets the length and the payload bits
                            seen_next = 3'd1;
                            if (b >= usd_pkg::LEAD6)
                            begin
                                needed_next = 3'd6;
                                acc_next    = CW'(b[0]);
                            end
                            else if (b >= usd_pkg::LEAD5)
                            begin
                                needed_next = 3'd5;
                                acc_next    = CW'(b[1:0]);
                            end
                            else if (b >= usd_pkg::LEAD4)
                            begin
                                needed_next = 3'd4;
                                acc_next    = CW'(b[2:0]);
                            end
                            else if (b >= usd_pkg::LEAD3)
                            begin
                                needed_next = 3'd3;
                                acc_next    = CW'(b[3:0]);
                            end
                            else if (b >= usd_pkg::LEAD2)
                            begin
                                needed_next = 3'd2;
                                acc_next    = CW'(b[4:0]);
                            end
                            else
                            begin
                                // ascii and stray continuation bytes pass as themselves
                                seen_next      = '0;
                                res_valid      = 1'b1;
                                res.code_point = CW'(b);
                            end
                        end
                        else
                        begin
                            acc_next  = {acc_reg[CW-7:0], b[5:0] & usd_pkg::CONT_MASK[5:0]};
                            seen_next = seen_reg + 3'd1;
                            if (seen_next >= needed_reg)
                            begin
                                res_valid      = 1'b1;
                                res.code_point = acc_next;
                                needed_next    = '0;
                                seen_next      = '0;
                                acc_next       = '0;
                            end
                        end
                    end

                    usd_pkg::ENC_UTF16_BE, usd_pkg::ENC_UTF16_LE,
                    usd_pkg::ENC_UTF32_BE, usd_pkg::ENC_UTF32_LE:
                    begin
                        unit_len = (enc_reg == usd_pkg::ENC_UTF16_BE ||
                                    enc_reg == usd_pkg::ENC_UTF16_LE) ?
                                   usd_pkg::LEN_UTF16 : usd_pkg::LEN_UTF32;
                        if (needed_reg == 3'd0)
                        begin
                            seen_base = '0;
                            acc_base  = '0;
                        end
                        if (enc_reg == usd_pkg::ENC_UTF16_BE ||
                            enc_reg == usd_pkg::ENC_UTF32_BE)
                        begin
                            acc_next = {acc_base[CW-9:0], b};
                        end
                        else
                        begin
                            // bit 31 of a utf-32 unit falls off the top
                            acc_next = acc_base | (CW'(b) << {seen_base[1:0], 3'b000});
                        end
                        seen_next   = seen_base + 3'd1;
                        needed_next = unit_len;
                        if (seen_next >= unit_len)
                        begin
                            res_valid      = 1'b1;
                            res.code_point = acc_next;
                            needed_next    = '0;
                            seen_next      = '0;
                            acc_next       = '0;
                        end
                    end

                    default:
                    begin
                        // unused encoding codes drop data bytes
                        res_valid = 1'b0;
                    end
                endcase
            end
        end

        // register write abandons any unit in progress
        if (cfg_we)
        begin
            enc_next    = cfg_data;
            needed_next = '0;
            seen_next   = '0;
            acc_next    = '0;
        end
    end

    // output entries: result register in front, skid register behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg        <= usd_pkg::ENC_UTF8;
            needed_reg     <= '0;
            seen_reg       <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            enc_reg        <= enc_next;
            needed_reg     <= needed_next;
            seen_reg       <= seen_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
